FILE: src/double_ended_queue_defines.svh
// assertion macros shared by the deque checker
// no dependencies; expects clk and rst in the scope of each use
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/deq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies
`default_nettype none

package deq_pkg;

  // default sizes
  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_DATA_WIDTH = 32;

  // request operation codes
  localparam logic [1:0] OP_PUSH_RIGHT = 2'd0;
  localparam logic [1:0] OP_PUSH_LEFT  = 2'd1;
  localparam logic [1:0] OP_POP_RIGHT  = 2'd2;
  localparam logic [1:0] OP_POP_LEFT   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic exec;      // request accepted: access memory, update pointers
    logic load_out;  // move the staged result into the output register
  } deq_cmd_t;

endpackage

`default_nettype wire

FILE: src/double_ended_queue.sv
// Double-ended queue of signed DATA_WIDTH-bit words held in a ring of DEPTH
// entries; built from deq_ctrl and deq_datapath, types from deq_pkg. Each
// request pushes or pops at the right or left end and returns one result with
// the popped word (zero unless a pop succeeded), a status (done, pop on empty,
// push on full dropped) and the fill count after the request. The ring memory
// is written or read at the acceptance edge, and the registered read data
// moves into the output register once that register is free; no new request
// is taken until the staged result has moved there. A new request is accepted
// while a previous result still waits in the output register; its result then
// waits until that register is free.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic signed [DATA_WIDTH-1:0]  push_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]       pop_value,
  output logic [1:0]                         status,
  output logic [$clog2(DEPTH+1)-1:0]         fill_count
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  // request sequencing
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // storage and pointers
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
  );

endmodule

`default_nettype wire

FILE: src/deq_ctrl.sv
// request sequencing and output handshake for the double-ended queue
// depends on deq_pkg
`default_nettype none

module deq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output deq_pkg::deq_cmd_t     cmd
);
  import deq_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_FINISH = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  // command decode
  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.exec     = in_valid && in_ready;
    cmd.load_out = (state == S_FINISH) && (!out_valid || out_ready);
  end

  // next state and output valid
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.exec) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/deq_datapath.sv
// ring memory, front pointer, entry count and result registers of the deque
// depends on deq_pkg
`default_nettype none

module deq_datapath #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire deq_pkg::deq_cmd_t             cmd,
  input  wire logic [1:0]                    op,
  input  wire logic signed [DATA_WIDTH-1:0]  push_value,
  output logic signed [DATA_WIDTH-1:0]       pop_value,
  output logic [1:0]                         status,
  output logic [$clog2(DEPTH+1)-1:0]         fill_count
);
  import deq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]         front;
  logic [PW-1:0]         front_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  logic                  is_pop;
  logic                  full;
  logic                  empty;
  logic [SW-1:0]         right_raw;
  logic [PW-1:0]         right_slot;
  logic [PW-1:0]         front_dec;
  logic [PW-1:0]         front_inc;
  logic [PW-1:0]         slot;
  logic                  wr_en;
  logic                  rd_en;
  logic [1:0]            res_code;

  logic [DATA_WIDTH-1:0] rd_data;
  logic                  rd_ok;
  logic [1:0]            res_status;
  logic [CW-1:0]         res_fill;

  // address and pointer arithmetic for the request on the input ports
  always_comb begin
    is_pop     = (op == OP_POP_RIGHT) || (op == OP_POP_LEFT);
    full       = (count == CW'(DEPTH));
    empty      = (count == '0);
    // right end: front + count for a push, front + count - 1 for a pop
    right_raw  = SW'(front) + SW'(count) - SW'(is_pop);
    right_slot = (right_raw >= SW'(DEPTH)) ? PW'(right_raw - SW'(DEPTH)) : PW'(right_raw);
    front_dec  = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);
    front_inc  = (front == PW'(DEPTH - 1)) ? '0 : front + PW'(1);

    slot       = right_slot;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    front_next = front;
    count_next = count;
    res_code   = ST_DONE;
    case (op)
      OP_PUSH_RIGHT: begin
        if (full) begin
          res_code = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_PUSH_LEFT: begin
        if (full) begin
          res_code = ST_FULL;
        end else begin
          slot       = front_dec;
          wr_en      = 1'b1;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      OP_POP_RIGHT: begin
        if (empty) begin
          res_code = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          count_next = count - CW'(1);
        end
      end
      OP_POP_LEFT: begin
        if (empty) begin
          res_code = ST_EMPTY;
        end else begin
          slot       = front;
          rd_en      = 1'b1;
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      default: res_code = ST_DONE;
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // ring memory, one access per request
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[slot] <= $unsigned(push_value);
    if (cmd.exec && rd_en) rd_data <= mem[slot];
  end

  // staged result and output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_ok      <= rd_en;
      res_status <= res_code;
      res_fill   <= count_next;
    end
    if (cmd.load_out) begin
      pop_value  <= rd_ok ? $signed(rd_data) : '0;
      status     <= res_status;
      fill_count <= res_fill;
    end
  end

endmodule

`default_nettype wire

FILE: src/deq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_defines.svh
`default_nettype none

`include "double_ended_queue_defines.svh"

module deq_checker #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [DATA_WIDTH-1:0]  pop_value,
  input wire logic [1:0]                    status,
  input wire logic [$clog2(DEPTH+1)-1:0]    fill_count
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // a stalled result stays up
  `DEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result dropped while stalled")

  // a stalled result keeps its payload
  `DEQ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(pop_value) && $stable(status) && $stable(fill_count),
    "result payload changed while stalled")

  // one request in flight at a time
  `DEQ_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready,
    "request taken while one is in flight")

  // status agrees with the fill count
  `DEQ_ASSERT_NOW(a_status_fill, out_valid && (status == ST_EMPTY || status == ST_FULL),
    (status == ST_EMPTY && fill_count == '0) ||
    (status == ST_FULL && fill_count == CW'(DEPTH)),
    "status and fill count disagree")

  // refused requests return a zero word
  `DEQ_ASSERT_NOW(a_refused_zero, out_valid && status != ST_DONE, pop_value == '0,
    "refused request returned a word")

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (.*);

`default_nettype wire

FILE: test/double_ended_queue_test.sv
// testbench for double_ended_queue: pushes and pops at both ends with random idling
// depends on deq_pkg and double_ended_queue; results are checked against a local deque model
`timescale 1ns / 100ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int DEPTH       = DEQ_DEPTH;
  localparam int DW          = DEQ_DATA_WIDTH;
  localparam int FILL_W      = $clog2(DEQ_DEPTH + 1);
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQS = 1250;

  typedef struct packed {
    logic [1:0]           op;
    logic signed [DW-1:0] value;
  } deq_request_t;

  typedef struct packed {
    logic signed [DW-1:0] pop_value;
    logic [1:0]           status;
    logic [FILL_W-1:0]    fill_count;
  } deq_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           op = OP_PUSH_RIGHT;
  logic signed [DW-1:0] push_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] pop_value;
  logic [1:0]           status;
  logic [FILL_W-1:0]    fill_count;

  // requests waiting to be driven and results still owed by the block
  deq_request_t pending_requests[$];
  deq_result_t  owed_results[$];

  // local copy of the deque
  logic signed [DW-1:0] ring_words [DEPTH];
  int                   ring_front = 0;
  int                   ring_count = 0;

  bit req_taken = 1'b0;
  int requests_taken = 0;
  int results_taken = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  bit held_off = 1'b0;
  int stall_left = 0;

  double_ended_queue i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .fill_count (fill_count)
  );

  always #2 clk = ~clk;

  function automatic void add_request(logic [1:0] req_op, logic signed [DW-1:0] req_value);
    pending_requests.push_back({req_op, req_value});
  endfunction

  // apply one request to the local deque and work out its result
  task automatic advance_deque(input deq_request_t req, output deq_result_t res);
    int slot;
    res.pop_value = '0;
    res.status    = ST_DONE;
    case (req.op)
      OP_PUSH_RIGHT: begin
        if (ring_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = (ring_front + ring_count) % DEPTH;
          ring_words[slot] = req.value;
          ring_count++;
        end
      end
      OP_PUSH_LEFT: begin
        if (ring_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring_words[ring_front] = req.value;
          ring_count++;
        end
      end
      OP_POP_RIGHT: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (ring_front + ring_count - 1) % DEPTH;
          res.pop_value = ring_words[slot];
          ring_count--;
        end
      end
      default: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = ring_words[ring_front];
          ring_front = (ring_front + 1) % DEPTH;
          ring_count--;
        end
      end
    endcase
    res.fill_count = FILL_W'(ring_count);
  endtask

  task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch in %s at result %0d: got %h, expected %h",
             field, results_taken, got, want);
    mismatches++;
  endtask

  // request driver: holds a request until taken, idles at random outside the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_requests.size() != 0 &&
          ((requests_taken >= 600 && requests_taken < 800) || $urandom_range(99) >= 38)) begin
        in_valid   <= 1'b1;
        op         <= pending_requests[0].op;
        push_value <= pending_requests[0].value;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: one long hold-off to back the block up, random stalls outside the calm stretch
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!held_off && results_taken >= 300) begin
        held_off   = 1'b1;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_taken >= 600 && results_taken < 800) ||
                     ($urandom_range(99) >= 38);
      end
    end
  end

  // monitor: check results, predict accepted requests, watch for a hang
  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    if (rst) begin
      req_taken    = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = '{pop_value, status, fill_count};
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", pop_value, '0);
        end else begin
          want = owed_results.pop_front();
          if (got.pop_value !== want.pop_value)
            report_mismatch("pop_value", got.pop_value, want.pop_value);
          if (got.status !== want.status)
            report_mismatch("status", DW'(got.status), DW'(want.status));
          if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", DW'(got.fill_count), DW'(want.fill_count));
        end
        results_taken++;
      end
      if (req_taken) begin
        advance_deque('{op, push_value}, want);
        owed_results.push_back(want);
        requests_taken++;
      end
      if (req_taken || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int bias_choices[5];
    int made;
    int seg_len;
    int bias;
    int k;
    logic [1:0] rop;
    logic signed [DW-1:0] rval;

    bias_choices = '{10, 30, 50, 70, 90};

    // pops on an empty queue
    add_request(OP_POP_RIGHT, 32'sh0000_0000);
    add_request(OP_POP_LEFT, 32'shffff_ffff);
    // fill from both ends, front pointer wraps below zero
    for (k = 0; k < DEPTH; k++) begin
      case (k % 4)
        0: rval = 32'sh7fff_ffff;
        1: rval = 32'sh8000_0000;
        2: rval = 32'sh0000_0000;
        default: rval = 32'shffff_ffff;
      endcase
      if (k % 3 == 0) rval = rval ^ (32'sh1 << k);
      add_request((k % 2) ? OP_PUSH_LEFT : OP_PUSH_RIGHT, rval);
    end
    // pushes into a full queue are dropped
    add_request(OP_PUSH_RIGHT, 32'sh1234_5678);
    add_request(OP_PUSH_LEFT, 32'sh8765_4321);
    add_request(OP_POP_LEFT, 32'sh0);
    add_request(OP_POP_RIGHT, 32'sh0);

    // random segments, each leaning toward pushes or pops to reach full and empty
    made = 0;
    while (made < RANDOM_REQS) begin
      seg_len = $urandom_range(16, 80);
      bias    = bias_choices[$urandom_range(0, 4)];
      for (k = 0; k < seg_len; k++) begin
        if ($urandom_range(99) < bias) rop = $urandom_range(1) ? OP_PUSH_LEFT : OP_PUSH_RIGHT;
        else rop = $urandom_range(1) ? OP_POP_LEFT : OP_POP_RIGHT;
        case ($urandom_range(0, 7))
          0: rval = 32'sh7fff_ffff;
          1: rval = 32'sh8000_0000;
          2: rval = 32'sh0000_0000;
          3: rval = 32'shffff_ffff;
          default: rval = $urandom;
        endcase
        add_request(rop, rval);
        made++;
      end
    end

    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() != 0 || in_valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
